FILE: hw/rtl/euler_rotate_translate_point_assert.svh
// Assertion macros for the point transform block.
`ifndef EULER_ROTATE_TRANSLATE_POINT_ASSERT_SVH
`define EULER_ROTATE_TRANSLATE_POINT_ASSERT_SVH
`ifndef SYNTHESIS
`define ERTP_CHECK(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("ertp check failed");
`define ERTP_CHECK_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("ertp check failed");
`else
`define ERTP_CHECK(lbl, ante, cons)
`define ERTP_CHECK_NEXT(lbl, ante, cons)
`endif
`endif

FILE: hw/rtl/ertp_pkg.sv
// Opcodes and fixed-point constants of the point transform.
`default_nettype none
package ertp_pkg;
   typedef enum logic [2:0] {
      OP_TRANSLATE = 3'd0,
      OP_ROT_X     = 3'd1,
      OP_ROT_Y     = 3'd2,
      OP_ROT_Z     = 3'd3,
      OP_ROT_ZYX   = 3'd4,
      OP_ROT_SHIFT = 3'd5
   } op_type;

   localparam int ONE_Q16      = 65536;
   localparam int PI_Q16       = 205887;
   localparam int HALF_PI_Q16  = 102944;
   localparam int TWO_PI_Q16   = 411775;
   localparam int CORDIC_GAIN  = 39797;
   localparam int CORDIC_STEPS = 16;
   localparam int ATAN_Q16 [0:CORDIC_STEPS-1] = '{
      51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
      256, 128, 64, 32, 16, 8, 4, 2
   };
endpackage
`default_nettype wire

FILE: hw/rtl/euler_rotate_translate_point.sv
// Pipelined 3D point rotate/translate with on-chip CORDIC sine and cosine.
`default_nettype none
// Transforms one point per word: v' = M*v + T, M built from roll, pitch and yaw
// (Rx*Ry*Rz for the combined ops), coordinates signed Q16.8, angles Q3.13 rad.
// Throughput is one word per clock while the output register is empty or being
// taken; the stages are range reduction, the 16 CORDIC stages, fold undo, two
// matrix product stages, entry select, vector multiply, accumulate and the
// round/saturate output register. All stages advance together whenever the
// output register is empty or being taken, so a stall freezes the pipe without
// losing or repeating words. Undefined opcodes pass the point through with
// overflow clear. rsp_tuser[0] flags that some coordinate saturated.
module euler_rotate_translate_point #(
   parameter int COORD_WIDTH = 24,
   parameter int ANGLE_WIDTH = 16
) (
   input  wire  logic clock,
   input  wire  logic reset,
   input  wire  logic req_tvalid,
   output logic       req_tready,
   // pos_x, pos_y, pos_z, roll_angle, pitch_angle, yaw_angle,
   // shift_x, shift_y, shift_z (low to high), zero padded
   input  wire  logic [((6*COORD_WIDTH+3*ANGLE_WIDTH+7)/8)*8-1:0] req_tdata,
   // req_type
   input  wire  logic [2:0] req_tuser,
   output logic       rsp_tvalid,
   input  wire  logic rsp_tready,
   // out_x, out_y, out_z (low to high), zero padded
   output logic [((3*COORD_WIDTH+7)/8)*8-1:0] rsp_tdata,
   // overflow
   output logic [0:0] rsp_tuser
);
   import ertp_pkg::*;

   localparam int CW = COORD_WIDTH;
   localparam int AW = ANGLE_WIDTH;
   localparam int RW = ((3*CW+7)/8)*8;
   localparam int MAGW = (AW + 3 > 21) ? AW + 3 : 21;   // reduction magnitude
   localparam int RED_STEPS = (AW > 16) ? AW - 15 : 1;
   localparam int ZW = 21;                             // angle, 2^-16 rad
   localparam int XW = 20;                             // trig values, Q.16
   localparam int ME = XW + 1;                         // matrix entries
   localparam int PW = ME + CW;                        // entry * coordinate
   localparam int ACCW = CW + 24;
   localparam int SW = ACCW - 16;
   localparam int NST = 25;
   localparam int S_MSEL = 21;
   localparam int S_VMUL = 22;

   localparam logic [MAGW:0] TP_MAG = (MAGW+1)'(TWO_PI_Q16);
   localparam logic signed [ZW-1:0] Z_PI = ZW'(PI_Q16);
   localparam logic signed [ZW-1:0] Z_2PI = ZW'(TWO_PI_Q16);
   localparam logic signed [ZW-1:0] Z_HPI = ZW'(HALF_PI_Q16);
   localparam logic signed [SW-1:0] S_MAX = SW'((64'sd1 <<< (CW-1)) - 64'sd1);
   localparam logic signed [SW-1:0] S_MIN = -S_MAX - SW'(1);

   typedef struct packed {
      logic [2:0]                   op;
      logic signed [2:0][CW-1:0]    pos;
      logic signed [2:0][CW-1:0]    sh;
   } carry_type;

   function automatic logic signed [XW-1:0] mulq(input logic signed [XW-1:0] a,
                                                 input logic signed [XW-1:0] b);
      logic signed [2*XW-1:0] p;
      p = a * b + (2*XW)'(32768);
      return XW'(p >>> 16);
   endfunction

   logic adv;
   logic [NST-1:0] vld_ff;
   carry_type car_ff [0:S_VMUL-1];
   carry_type car_in;

   assign adv = !vld_ff[NST-1] || rsp_tready;
   assign req_tready = adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[NST-2:0], req_tvalid};
      end
   end

   // input fields
   logic signed [AW-1:0] ang [0:2];
   always_comb begin
      for (int r = 0; r < 3; r++) begin
         car_in.pos[r] = req_tdata[r*CW +: CW];
         car_in.sh[r]  = req_tdata[3*CW + 3*AW + r*CW +: CW];
         ang[r]        = req_tdata[3*CW + r*AW +: AW];
      end
      car_in.op = req_tuser;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         car_ff[0] <= car_in;
         for (int s = 1; s < S_VMUL; s++) car_ff[s] <= car_ff[s-1];
      end
   end

   // stage 0: scale by 8, truncated remainder by 2*pi
   logic signed [ZW-1:0] zred_in [0:2];
   logic signed [ZW-1:0] zred_ff [0:2];
   always_comb begin
      logic signed [MAGW:0] a8;
      logic [MAGW:0] mag;
      for (int l = 0; l < 3; l++) begin
         a8 = (MAGW+1)'(ang[l]) <<< 3;
         mag = a8[MAGW] ? (MAGW+1)'(-a8) : (MAGW+1)'(a8);
         for (int k = RED_STEPS - 1; k >= 0; k--) begin
            if (mag >= (TP_MAG << k)) mag = mag - (TP_MAG << k);
         end
         zred_in[l] = a8[MAGW] ? -ZW'(mag) : ZW'(mag);
      end
   end

   // stage 1: fold into +-pi/2, CORDIC seed
   logic signed [XW-1:0] cx_ff [0:CORDIC_STEPS][0:2];
   logic signed [XW-1:0] cy_ff [0:CORDIC_STEPS][0:2];
   logic signed [ZW-1:0] cz_ff [0:CORDIC_STEPS][0:2];
   logic                 cn_ff [0:CORDIC_STEPS][0:2];
   logic signed [ZW-1:0] zf_in [0:2];
   logic                 nf_in [0:2];
   always_comb begin
      logic signed [ZW-1:0] z;
      for (int l = 0; l < 3; l++) begin
         z = zred_ff[l];
         nf_in[l] = 1'b0;
         if (z > Z_PI) z = z - Z_2PI;
         else if (z < -Z_PI) z = z + Z_2PI;
         if (z > Z_HPI) begin
            z = z - Z_PI;
            nf_in[l] = 1'b1;
         end else if (z < -Z_HPI) begin
            z = z + Z_PI;
            nf_in[l] = 1'b1;
         end
         zf_in[l] = z;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         zred_ff <= zred_in;
         for (int l = 0; l < 3; l++) begin
            cx_ff[0][l] <= XW'(CORDIC_GAIN);
            cy_ff[0][l] <= '0;
            cz_ff[0][l] <= zf_in[l];
            cn_ff[0][l] <= nf_in[l];
         end
      end
   end

   // stages 2..17: one CORDIC rotation per stage, three lanes
   for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
      always_ff @(posedge clock) begin
         if (adv) begin
            for (int l = 0; l < 3; l++) begin
               if (cz_ff[i][l] >= 0) begin
                  cx_ff[i+1][l] <= cx_ff[i][l] - (cy_ff[i][l] >>> i);
                  cy_ff[i+1][l] <= cy_ff[i][l] + (cx_ff[i][l] >>> i);
                  cz_ff[i+1][l] <= cz_ff[i][l] - ZW'(ATAN_Q16[i]);
               end else begin
                  cx_ff[i+1][l] <= cx_ff[i][l] + (cy_ff[i][l] >>> i);
                  cy_ff[i+1][l] <= cy_ff[i][l] - (cx_ff[i][l] >>> i);
                  cz_ff[i+1][l] <= cz_ff[i][l] + ZW'(ATAN_Q16[i]);
               end
               cn_ff[i+1][l] <= cn_ff[i][l];
            end
         end
      end
   end

   // stage 18: undo the fold; lanes are roll, pitch, yaw
   logic signed [XW-1:0] cos_ff [0:2];
   logic signed [XW-1:0] sin_ff [0:2];
   always_ff @(posedge clock) begin
      if (adv) begin
         for (int l = 0; l < 3; l++) begin
            cos_ff[l] <= cn_ff[CORDIC_STEPS][l] ? -cx_ff[CORDIC_STEPS][l]
                                                 : cx_ff[CORDIC_STEPS][l];
            sin_ff[l] <= cn_ff[CORDIC_STEPS][l] ? -cy_ff[CORDIC_STEPS][l]
                                                 : cy_ff[CORDIC_STEPS][l];
         end
      end
   end

   // stage 19: first-level products
   logic signed [XW-1:0] spcy_ff, spsy_ff, cpcy_ff, cpsy_ff, crsy_ff;
   logic signed [XW-1:0] srsy_ff, crcy_ff, srcy_ff, srcp_ff, crcp_ff;
   logic signed [XW-1:0] ta_c_ff [0:2];
   logic signed [XW-1:0] ta_s_ff [0:2];
   always_ff @(posedge clock) begin
      if (adv) begin
         spcy_ff <= mulq(sin_ff[1], cos_ff[2]);
         spsy_ff <= mulq(sin_ff[1], sin_ff[2]);
         cpcy_ff <= mulq(cos_ff[1], cos_ff[2]);
         cpsy_ff <= mulq(cos_ff[1], sin_ff[2]);
         crsy_ff <= mulq(cos_ff[0], sin_ff[2]);
         srsy_ff <= mulq(sin_ff[0], sin_ff[2]);
         crcy_ff <= mulq(cos_ff[0], cos_ff[2]);
         srcy_ff <= mulq(sin_ff[0], cos_ff[2]);
         srcp_ff <= mulq(sin_ff[0], cos_ff[1]);
         crcp_ff <= mulq(cos_ff[0], cos_ff[1]);
         ta_c_ff <= cos_ff;
         ta_s_ff <= sin_ff;
      end
   end

   // stage 20: triple terms and the combined rotation matrix
   logic signed [ME-1:0] rz_ff [0:8];
   logic signed [XW-1:0] tb_c_ff [0:2];
   logic signed [XW-1:0] tb_s_ff [0:2];
   always_ff @(posedge clock) begin
      if (adv) begin
         rz_ff[0] <= ME'(cpcy_ff);
         rz_ff[1] <= -ME'(cpsy_ff);
         rz_ff[2] <= ME'(ta_s_ff[1]);
         rz_ff[3] <= ME'(crsy_ff) + ME'(mulq(ta_s_ff[0], spcy_ff));
         rz_ff[4] <= ME'(crcy_ff) - ME'(mulq(ta_s_ff[0], spsy_ff));
         rz_ff[5] <= -ME'(srcp_ff);
         rz_ff[6] <= ME'(srsy_ff) - ME'(mulq(ta_c_ff[0], spcy_ff));
         rz_ff[7] <= ME'(srcy_ff) + ME'(mulq(ta_c_ff[0], spsy_ff));
         rz_ff[8] <= ME'(crcp_ff);
         tb_c_ff <= ta_c_ff;
         tb_s_ff <= ta_s_ff;
      end
   end

   // stage 21: matrix and translation by opcode
   logic signed [ME-1:0] m_in [0:8];
   logic signed [ME-1:0] m_ff [0:8];
   logic signed [CW-1:0] t_in [0:2];
   logic signed [CW-1:0] t_ff [0:2];
   logic signed [CW-1:0] t2_ff [0:2];
   always_comb begin
      for (int e = 0; e < 9; e++) m_in[e] = (e % 4 == 0) ? ME'(ONE_Q16) : '0;
      for (int r = 0; r < 3; r++) t_in[r] = '0;
      unique case (car_ff[S_MSEL-1].op)
         OP_TRANSLATE: begin
            for (int r = 0; r < 3; r++) t_in[r] = car_ff[S_MSEL-1].sh[r];
         end
         OP_ROT_X: begin
            m_in[4] = ME'(tb_c_ff[0]);
            m_in[5] = -ME'(tb_s_ff[0]);
            m_in[7] = ME'(tb_s_ff[0]);
            m_in[8] = ME'(tb_c_ff[0]);
         end
         OP_ROT_Y: begin
            m_in[0] = ME'(tb_c_ff[1]);
            m_in[2] = ME'(tb_s_ff[1]);
            m_in[6] = -ME'(tb_s_ff[1]);
            m_in[8] = ME'(tb_c_ff[1]);
         end
         OP_ROT_Z: begin
            m_in[0] = ME'(tb_c_ff[2]);
            m_in[1] = -ME'(tb_s_ff[2]);
            m_in[3] = ME'(tb_s_ff[2]);
            m_in[4] = ME'(tb_c_ff[2]);
         end
         OP_ROT_ZYX: begin
            m_in = rz_ff;
         end
         OP_ROT_SHIFT: begin
            m_in = rz_ff;
            for (int r = 0; r < 3; r++) t_in[r] = car_ff[S_MSEL-1].sh[r];
         end
         default: begin
            // undefined code: identity, no translation
         end
      endcase
   end

   // stage 22: nine entry * coordinate products
   logic signed [PW-1:0] pr_ff [0:8];
   always_ff @(posedge clock) begin
      if (adv) begin
         m_ff <= m_in;
         t_ff <= t_in;
         for (int e = 0; e < 9; e++)
            pr_ff[e] <= PW'(m_ff[e]) * PW'($signed(car_ff[S_VMUL-1].pos[e % 3]));
         t2_ff <= t_ff;
      end
   end

   // stage 23: row sums with translation; stage 24: round and saturate
   logic signed [ACCW-1:0] acc_ff [0:2];
   logic signed [CW-1:0]   out_ff [0:2];
   logic                   ovf_ff;
   logic signed [CW-1:0]   out_in [0:2];
   logic                   ovf_in;
   always_comb begin
      logic signed [SW-1:0] res;
      ovf_in = 1'b0;
      for (int r = 0; r < 3; r++) begin
         res = SW'((acc_ff[r] + ACCW'(32768)) >>> 16);
         if (res > S_MAX) begin
            res = S_MAX;
            ovf_in = 1'b1;
         end else if (res < S_MIN) begin
            res = S_MIN;
            ovf_in = 1'b1;
         end
         out_in[r] = CW'(res);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int r = 0; r < 3; r++)
            acc_ff[r] <= ACCW'(pr_ff[3*r]) + ACCW'(pr_ff[3*r+1]) + ACCW'(pr_ff[3*r+2])
                         + (ACCW'(t2_ff[r]) <<< 16);
         out_ff <= out_in;
         ovf_ff <= ovf_in;
      end
   end

   assign rsp_tvalid = vld_ff[NST-1];
   assign rsp_tdata  = RW'({out_ff[2], out_ff[1], out_ff[0]});
   assign rsp_tuser  = ovf_ff;

   // some output coordinate sits at a rail
   logic sat_any;
   assign sat_any = (SW'(out_ff[0]) == S_MAX) || (SW'(out_ff[0]) == S_MIN) ||
                    (SW'(out_ff[1]) == S_MAX) || (SW'(out_ff[1]) == S_MIN) ||
                    (SW'(out_ff[2]) == S_MAX) || (SW'(out_ff[2]) == S_MIN);

`include "euler_rotate_translate_point_assert.svh"
   `ERTP_CHECK_NEXT(a_stall_freeze, !adv, $stable(vld_ff))
   `ERTP_CHECK(a_fold_range, vld_ff[1], (cz_ff[0][0] <= Z_HPI) && (cz_ff[0][0] >= -Z_HPI))
   `ERTP_CHECK(a_ovf_sat, rsp_tvalid && ovf_ff, sat_any)
endmodule
`default_nettype wire

FILE: tb/sv/tb_euler_rotate_translate_point.sv
// Testbench for the pipelined 3D point rotate/translate block.
`timescale 1ns / 1ps
`default_nettype none

module tb_euler_rotate_translate_point;
   import ertp_pkg::*;

   localparam int CW = 24;
   localparam int AW = 16;
   localparam int REQ_W = ((6*CW+3*AW+7)/8)*8;
   localparam int RSP_W = ((3*CW+7)/8)*8;
   localparam int IDLE_LIMIT = 20000;
   localparam longint CMAX = (64'sd1 <<< (CW-1)) - 1;
   localparam longint CMIN = -CMAX - 1;

   // one transformed point as it leaves the block
   typedef struct packed {
      logic [CW-1:0] x;
      logic [CW-1:0] y;
      logic [CW-1:0] z;
      logic          ovf;
   } point_type;

   // ------------------------------------------------------------------
   // Scoreboard: predicts each transformed point and checks responses.
   // ------------------------------------------------------------------
   class point_scoreboard;
      point_type pending[$];
      int        errors;

      // arithmetic shift right, floor
      function longint asr(longint v, int s);
         return v >>> s;
      endfunction

      function longint mulq(longint a, longint b);
         return asr(a * b + 32768, 16);
      endfunction

      // CORDIC sine/cosine with range reduction to +-pi/2
      function void sincos(logic signed [AW-1:0] ang, output longint c, output longint s);
         longint z, x, y, nx;
         bit     neg;
         z = (longint'(ang) * 8) % TWO_PI_Q16;
         x = CORDIC_GAIN;
         y = 0;
         neg = 0;
         if (z > PI_Q16) z -= TWO_PI_Q16;
         if (z < -PI_Q16) z += TWO_PI_Q16;
         if (z > HALF_PI_Q16) begin
            z -= PI_Q16;
            neg = 1;
         end else if (z < -HALF_PI_Q16) begin
            z += PI_Q16;
            neg = 1;
         end
         for (int i = 0; i < CORDIC_STEPS; i++) begin
            if (z >= 0) begin
               nx = x - asr(y, i); y = y + asr(x, i); z -= ATAN_Q16[i];
            end else begin
               nx = x + asr(y, i); y = y - asr(x, i); z += ATAN_Q16[i];
            end
            x = nx;
         end
         c = neg ? -x : x;
         s = neg ? -y : y;
      endfunction

      // note an accepted request word and queue its transformed point
      function void note_request(logic [2:0] op, logic [REQ_W-1:0] d);
         longint m[3][3], t[3], v[3], acc, res;
         longint cr, sr, cp, sp, cy, sy, spcy, spsy;
         point_type p;
         for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) m[r][c] = (r == c) ? ONE_Q16 : 0;
            t[r] = 0;
            v[r] = longint'($signed(d[r*CW +: CW]));
         end
         sincos(d[3*CW      +: AW], cr, sr);
         sincos(d[3*CW+AW   +: AW], cp, sp);
         sincos(d[3*CW+2*AW +: AW], cy, sy);
         if (op == OP_TRANSLATE || op == OP_ROT_SHIFT)
            for (int r = 0; r < 3; r++) t[r] = longint'($signed(d[3*CW+3*AW+r*CW +: CW]));
         case (op)
            OP_ROT_X: begin
               m[1][1] = cr; m[1][2] = -sr; m[2][1] = sr; m[2][2] = cr;
            end
            OP_ROT_Y: begin
               m[0][0] = cp; m[0][2] = sp; m[2][0] = -sp; m[2][2] = cp;
            end
            OP_ROT_Z: begin
               m[0][0] = cy; m[0][1] = -sy; m[1][0] = sy; m[1][1] = cy;
            end
            OP_ROT_ZYX, OP_ROT_SHIFT: begin
               spcy = mulq(sp, cy);
               spsy = mulq(sp, sy);
               m[0][0] = mulq(cp, cy);
               m[0][1] = -mulq(cp, sy);
               m[0][2] = sp;
               m[1][0] = mulq(cr, sy) + mulq(sr, spcy);
               m[1][1] = mulq(cr, cy) - mulq(sr, spsy);
               m[1][2] = -mulq(sr, cp);
               m[2][0] = mulq(sr, sy) - mulq(cr, spcy);
               m[2][1] = mulq(sr, cy) + mulq(cr, spsy);
               m[2][2] = mulq(cr, cp);
            end
            default: ;
         endcase
         p.ovf = 0;
         for (int r = 0; r < 3; r++) begin
            acc = t[r] * ONE_Q16;
            for (int c = 0; c < 3; c++) acc += m[r][c] * v[c];
            res = asr(acc + 32768, 16);
            if (res > CMAX) begin res = CMAX; p.ovf = 1; end
            if (res < CMIN) begin res = CMIN; p.ovf = 1; end
            case (r)
               0: p.x = res[CW-1:0];
               1: p.y = res[CW-1:0];
               default: p.z = res[CW-1:0];
            endcase
         end
         pending.push_back(p);
      endfunction

      task report(string what, longint got, longint want);
         $display("mismatch %s: got %0h want %0h", what, got, want);
         errors++;
      endtask

      task check_response(logic [RSP_W-1:0] d, logic ovf);
         point_type w;
         if (pending.size() == 0) begin
            report("unexpected word", longint'(d[0 +: CW]), 0);
            return;
         end
         w = pending.pop_front();
         if (d[0 +: CW] !== w.x) report("out_x", d[0 +: CW], w.x);
         if (d[CW +: CW] !== w.y) report("out_y", d[CW +: CW], w.y);
         if (d[2*CW +: CW] !== w.z) report("out_z", d[2*CW +: CW], w.z);
         if (ovf !== w.ovf) report("overflow", ovf, w.ovf);
      endtask
   endclass

   logic             clock = 0;
   logic             reset = 1;
   logic             req_tvalid = 0;
   logic             req_tready;
   logic [REQ_W-1:0] req_tdata = '0;
   logic [2:0]       req_tuser = '0;
   logic             rsp_tvalid;
   logic             rsp_tready = 0;
   logic [RSP_W-1:0] rsp_tdata;
   logic [0:0]       rsp_tuser;

   point_scoreboard sb = new();
   int  send_idle_pct = 0;   // sender gap odds, percent
   int  recv_stall_pct = 0;  // receiver stall odds, percent
   bit  hold_off = 0;        // long receiver hold-off in progress
   int  idle_cycles = 0;

   always #4 clock = ~clock;

   euler_rotate_translate_point #(.COORD_WIDTH(CW), .ANGLE_WIDTH(AW)) u_dut (
      .clock, .reset,
      .req_tvalid, .req_tready, .req_tdata, .req_tuser,
      .rsp_tvalid, .rsp_tready, .rsp_tdata, .rsp_tuser
   );

   // response side: check on the rising edge, pick tready on the falling edge
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_response(rsp_tdata, rsp_tuser[0]);
   end

   always @(negedge clock) begin
      rsp_tready <= !reset && !hold_off && ($urandom_range(99) >= recv_stall_pct);
   end

   // watchdog: cycles with no word moving on either side
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles <= 0;
      else if (!reset && !hold_off) idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("tb_euler_rotate_translate_point: done, errors");
         $finish;
      end
   end

   // random coordinate: moderate half the time, otherwise full scale or near a rail
   function automatic logic [CW-1:0] rand_coord();
      case ($urandom_range(3))
         0: return CW'($urandom());
         1: return $urandom_range(1) ? CW'(CMAX) - CW'($urandom_range(3))
                                     : CW'(CMIN) + CW'($urandom_range(3));
         default: return CW'($signed(17'($urandom())));
      endcase
   endfunction

   // random angle: within +-pi most of the time, full field otherwise
   function automatic logic [AW-1:0] rand_angle();
      if ($urandom_range(3) == 0) return AW'($urandom());
      return AW'($signed(32'($urandom_range(51472)) - 25736));
   endfunction

   // offer one word; waits for the handshake, keeps tvalid high if the next follows
   task automatic send_word(logic [2:0] op, logic [CW-1:0] px, py, pz,
                            logic [AW-1:0] ra, pa, ya, logic [CW-1:0] tx, ty, tz);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 0;
         @(negedge clock);
      end
      req_tuser <= op;
      req_tdata <= {tz, ty, tx, ya, pa, ra, pz, py, px};
      req_tvalid <= 1;
      do @(posedge clock); while (!req_tready);
      sb.note_request(op, {tz, ty, tx, ya, pa, ra, pz, py, px});
      @(negedge clock);
   endtask

   task automatic send_random();
      logic [2:0] op;
      op = ($urandom_range(15) == 0) ? 3'($urandom_range(7, 6)) : 3'($urandom_range(5));
      send_word(op, rand_coord(), rand_coord(), rand_coord(),
                rand_angle(), rand_angle(), rand_angle(),
                rand_coord(), rand_coord(), rand_coord());
   endtask

   task automatic drain();
      req_tvalid <= 0;
      while (sb.pending.size() != 0) @(negedge clock);
   endtask

   localparam logic [CW-1:0] PMAX = CW'(CMAX);
   localparam logic [CW-1:0] PMIN = CW'(CMIN);
   localparam logic [AW-1:0] A_PI = 16'sd25736;

   initial begin
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      // directed: each op at the extremes, wrap-around angles, unknown opcodes
      for (int o = 0; o < 8; o++) begin
         send_word(3'(o), PMAX, PMIN, 24'h000100, A_PI, -A_PI, 16'sd12868,
                   PMAX, PMAX, PMIN);
         send_word(3'(o), 24'h001000, 24'hFFF000, 24'h000800, 16'h7FFF, 16'h8000, 16'h0000,
                   24'h000001, 24'hFFFFFF, 24'h0);
      end
      send_word(OP_TRANSLATE, PMIN, PMIN, PMIN, '0, '0, '0, PMIN, PMIN, PMIN);
      send_word(OP_ROT_SHIFT, 24'hFFFFFF, 24'h555555, 24'hAAAAAA, 16'h5555, 16'hAAAA,
                16'hFFFF, 24'hAAAAAA, 24'h555555, 24'h0);
      drain();

      // random phases: none, sender gaps, receiver stalls, both
      for (int ph = 0; ph < 4; ph++) begin
         send_idle_pct  = (ph == 1) ? 63 : (ph == 3) ? 26 : 0;
         recv_stall_pct = (ph == 2) ? 63 : (ph == 3) ? 26 : 0;
         for (int i = 0; i < 380; i++) begin
            // long receiver hold-off mid phase 0 so the pipe fills and backs up
            if (ph == 0 && i == 100) fork
               begin
                  hold_off = 1;
                  repeat (200) @(negedge clock);
                  hold_off = 0;
               end
            join_none
            send_random();
         end
         drain();
      end

      repeat (60) @(negedge clock);
      if (sb.errors == 0 && sb.pending.size() == 0)
         $display("tb_euler_rotate_translate_point: done, clean");
      else
         $display("tb_euler_rotate_translate_point: done, errors");
      $finish;
   end
endmodule

`default_nettype wire

FILE: euler_rotate_translate_point.f
+incdir+hw/rtl
hw/rtl/ertp_pkg.sv
hw/rtl/euler_rotate_translate_point.sv
tb/sv/tb_euler_rotate_translate_point.sv
